>>> sv/jbhe_pkg.sv
// Shared types, constants and code tables of the JPEG block Huffman encoder.
package jbhe_pkg;

	localparam int COEFF_BITS = 12;
	localparam int AMP_W      = COEFF_BITS + 1;
	localparam int SIZE_W     = $clog2(AMP_W + 1);
	localparam int CODE_W     = 22;
	localparam int LEN_W      = 5;
	localparam int RUN_W      = 6;
	localparam int HC_W       = 16;
	localparam int DC_CATS    = 12;

	localparam logic [RUN_W-1:0]  RUN_MAX  = {RUN_W{1'b1}};
	localparam logic [CODE_W-1:0] EOB_CODE = CODE_W'(4'b1010);
	localparam logic [LEN_W-1:0]  EOB_LEN  = LEN_W'(4);

	typedef enum logic [1:0] {
		FUNC_DC  = 2'd0,
		FUNC_AC  = 2'd1,
		FUNC_EOB = 2'd2,
		FUNC_RSV = 2'd3
	} func_t;

	typedef struct packed {
		logic [SIZE_W-1:0] size;
		logic [AMP_W-1:0]  bits;
	} amp_t;

	typedef struct packed {
		logic             hit;
		logic [HC_W-1:0]  code;
		logic [LEN_W-1:0] len;
	} hc_t;

	typedef struct packed {
		logic [CODE_W-1:0] bits;
		logic [LEN_W-1:0]  len;
		logic              status;
	} res_t;

	function automatic hc_t mk_hc(input logic [HC_W-1:0] code, input int len);
		hc_t r;
		r.hit  = 1'b1;
		r.code = code;
		r.len  = LEN_W'(len);
		return r;
	endfunction

	// Size-category code for a DC difference.
	function automatic hc_t dc_lookup(input logic [SIZE_W-1:0] size);
		hc_t r;
		r = '0;
		case (int'(size))
			0:  r = mk_hc(HC_W'(12'h000), 2);
			1:  r = mk_hc(HC_W'(12'h002), 3);
			2:  r = mk_hc(HC_W'(12'h003), 3);
			3:  r = mk_hc(HC_W'(12'h004), 3);
			4:  r = mk_hc(HC_W'(12'h005), 3);
			5:  r = mk_hc(HC_W'(12'h006), 3);
			6:  r = mk_hc(HC_W'(12'h00E), 4);
			7:  r = mk_hc(HC_W'(12'h01E), 5);
			8:  r = mk_hc(HC_W'(12'h03E), 6);
			9:  r = mk_hc(HC_W'(12'h07E), 7);
			10: r = mk_hc(HC_W'(12'h0FE), 8);
			11: r = mk_hc(HC_W'(12'h1FE), 9);
			default: r = '0;
		endcase
		return r;
	endfunction

	// Run/size code for a nonzero AC coefficient; hit is low when the pair is absent.
	function automatic hc_t ac_lookup(input logic [RUN_W-1:0] run,
			input logic [SIZE_W-1:0] size);
		hc_t r;
		r = '0;
		case (int'(run))
			0: begin
				case (int'(size))
					1: r = mk_hc(16'h0000, 2);
					2: r = mk_hc(16'h0001, 2);
					3: r = mk_hc(16'h0004, 3);
					4: r = mk_hc(16'h000B, 4);
					5: r = mk_hc(16'h001A, 5);
					6: r = mk_hc(16'h0078, 7);
					default: r = '0;
				endcase
			end
			1: begin
				case (int'(size))
					1: r = mk_hc(16'h000C, 4);
					2: r = mk_hc(16'h001B, 5);
					3: r = mk_hc(16'h0079, 7);
					4: r = mk_hc(16'h01F6, 9);
					5: r = mk_hc(16'h07F6, 11);
					6: r = mk_hc(16'hFF84, 16);
					default: r = '0;
				endcase
			end
			5: begin
				if (int'(size) == 1) r = mk_hc(16'h007A, 7);
			end
			6: begin
				if (int'(size) == 2) r = mk_hc(16'h0FF6, 12);
			end
			10: begin
				if (int'(size) == 1) r = mk_hc(16'h01FA, 9);
			end
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

>>> sv/jbhe_amp.sv
// Size category and amplitude bits of a signed value.
module jbhe_amp (
	input  logic signed [jbhe_pkg::AMP_W-1:0] value,
	output jbhe_pkg::amp_t                    amp
);
	import jbhe_pkg::*;

	logic             neg;
	logic [AMP_W-1:0] mag;
	logic [AMP_W-1:0] mask;
	logic [SIZE_W-1:0] size;

	assign neg = value[AMP_W-1];
	assign mag = neg ? (~value + 1'b1) : value;

	// Bit length of the magnitude: position of the highest set bit, plus one.
	always_comb begin
		size = '0;
		for (int i = 0; i < AMP_W; i++) begin
			if (mag[i]) size = SIZE_W'(i + 1);
		end
	end

	always_comb begin
		for (int i = 0; i < AMP_W; i++) begin
			mask[i] = (i < int'(size));
		end
	end

	// Negative values send the one's complement of the magnitude.
	assign amp.size = size;
	assign amp.bits = neg ? (~mag & mask) : mag;

endmodule

>>> sv/jbhe_code.sv
// Code table lookup and assembly of the code word with its amplitude bits.
module jbhe_code (
	input  jbhe_pkg::func_t                 func,
	input  jbhe_pkg::amp_t                  amp,
	input  logic [jbhe_pkg::RUN_W-1:0]      zero_run,
	output jbhe_pkg::res_t                  res
);
	import jbhe_pkg::*;

	hc_t               hc;
	logic              dc_big;
	logic [CODE_W-1:0] packed_bits;
	logic [LEN_W-1:0]  packed_len;

	assign dc_big = (int'(amp.size) >= DC_CATS);

	always_comb begin
		case (func)
			FUNC_DC: hc = dc_lookup(amp.size);
			FUNC_AC: hc = ac_lookup(zero_run, amp.size);
			default: hc = '0;
		endcase
	end

	assign packed_bits = (CODE_W'(hc.code) << amp.size) | CODE_W'(amp.bits);
	assign packed_len  = hc.len + LEN_W'(amp.size);

	always_comb begin
		res = '0;
		case (func)
			FUNC_EOB: begin
				res.bits = EOB_CODE;
				res.len  = EOB_LEN;
			end
			FUNC_DC, FUNC_AC: begin
				if (hc.hit && !(func == FUNC_DC && dc_big)) begin
					res.bits = packed_bits;
					res.len  = packed_len;
				end else begin
					res.status = 1'b1;
				end
			end
			default: res = '0;
		endcase
	end

endmodule

>>> sv/jpeg_block_huffman_encoder_core.sv
// Top level of the JPEG block Huffman encoder: one zig-zag coefficient per transaction.
// Each result passes through the input register, then the result register;
// zero AC items and unused function codes give no result.
// Items are taken one per cycle unless a result is held in the result register by a receiver stall.
// Reset (arst_n, asynchronous, active low) empties both registers and clears the zero run.
module jpeg_block_huffman_encoder_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  logic [1:0]                           func,
	input  logic signed [jbhe_pkg::COEFF_BITS-1:0] coefficient,
	input  logic signed [jbhe_pkg::COEFF_BITS-1:0] prev_dc,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic [jbhe_pkg::CODE_W-1:0]          code_bits,
	output logic [jbhe_pkg::LEN_W-1:0]           code_length,
	output logic                                 status
);
	import jbhe_pkg::*;

	// Input register stage. It takes a new transaction whenever it is empty or its
	// current item moves on in the same cycle.
	logic                         valid_s1;
	func_t                        func_s1;
	logic signed [COEFF_BITS-1:0] coef_s1;
	logic signed [COEFF_BITS-1:0] prev_s1;

	// The zero run counts AC zeros since the last DC, nonzero AC or end-of-block.
	logic [RUN_W-1:0] zero_run_q;

	logic                    item_accept;
	logic                    s1_emits;
	logic                    res_free;
	logic                    advance_s1;
	logic signed [AMP_W-1:0] diff;
	logic signed [AMP_W-1:0] value;
	amp_t                    amp;
	res_t                    res;

	assign item_accept = item_valid && !item_stall;

	// An item produces a result unless it is an AC zero or the unused function code.
	assign s1_emits = valid_s1 && ((func_s1 == FUNC_DC) || (func_s1 == FUNC_EOB) ||
		((func_s1 == FUNC_AC) && (coef_s1 != '0)));

	// The result register can take a new result when it is empty or being drained.
	assign res_free   = !result_valid || !result_stall;
	assign advance_s1 = valid_s1 && (!s1_emits || res_free);
	assign item_stall = valid_s1 && !advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_accept) begin
			func_s1 <= func_t'(func);
			coef_s1 <= coefficient;
			prev_s1 <= prev_dc;
		end
	end

	// DC items code the difference to the previous block's DC, which needs one more
	// bit than a coefficient; AC items code the coefficient itself.
	assign diff  = {coef_s1[COEFF_BITS-1], coef_s1} - {prev_s1[COEFF_BITS-1], prev_s1};
	assign value = (func_s1 == FUNC_DC) ? diff : {coef_s1[COEFF_BITS-1], coef_s1};

	jbhe_amp u_amp (
		.value (value),
		.amp   (amp)
	);

	jbhe_code u_code (
		.func     (func_s1),
		.amp      (amp),
		.zero_run (zero_run_q),
		.res      (res)
	);

	// The run is updated as the item leaves the input stage, so each lookup sees the
	// run left by all earlier items in order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_run_q <= '0;
		end else if (advance_s1) begin
			case (func_s1)
				FUNC_DC, FUNC_EOB: zero_run_q <= '0;
				FUNC_AC: begin
					if (coef_s1 != '0) begin
						zero_run_q <= '0;
					end else if (zero_run_q != RUN_MAX) begin
						zero_run_q <= zero_run_q + 1'b1;
					end
				end
				default: zero_run_q <= zero_run_q;
			endcase
		end
	end

	// Result register; it holds its transaction while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance_s1 && s1_emits) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && s1_emits) begin
			code_bits   <= res.bits;
			code_length <= res.len;
			status      <= res.status;
		end
	end

	// A flagged result carries no bits.
	a_status_empty: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status |-> (code_length == '0) && (code_bits == '0))
		else $error("flagged result carries code bits");

	// Every emitted code has at least one bit.
	a_code_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !status |-> code_length != '0)
		else $error("emitted code has zero length");

	// DC and end-of-block items restart the run.
	a_run_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		advance_s1 && ((func_s1 == FUNC_DC) || (func_s1 == FUNC_EOB)) |=> zero_run_q == '0)
		else $error("zero run not cleared");

	// The input side stalls only while the input register holds a blocked item.
	a_stall_reason: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1 && s1_emits && result_valid && result_stall)
		else $error("input stalled without a blocked result");

endmodule

>>> tb/jpeg_block_huffman_encoder_core_checker.sv
// Checker for the JPEG block Huffman encoder: predicts each codeword and compares results.
`timescale 1ns / 100ps

module jpeg_block_huffman_encoder_core_checker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   item_valid,
	input  logic                                   item_stall,
	input  logic [1:0]                             func,
	input  logic signed [jbhe_pkg::COEFF_BITS-1:0] coefficient,
	input  logic signed [jbhe_pkg::COEFF_BITS-1:0] prev_dc,
	input  logic                                   result_valid,
	input  logic                                   result_stall,
	input  logic [jbhe_pkg::CODE_W-1:0]            code_bits,
	input  logic [jbhe_pkg::LEN_W-1:0]             code_length,
	input  logic                                   status,
	output int                                     fail_count,
	output int                                     pending
);
	import jbhe_pkg::*;

	localparam int DC_TOP_SIZE = 11;
	localparam int RUN_LIMIT   = 63;

	res_t             expected_codes [$];
	logic [RUN_W-1:0] zero_count = '0;
	int               fails      = 0;
	int               waiting    = 0;

	assign fail_count = fails;
	assign pending    = waiting;

	// Bit length of the magnitude, and the magnitude or its one's complement for negatives.
	function automatic void amplitude_of(input int v, output int size, output int bits);
		int mag;
		mag  = (v < 0) ? -v : v;
		size = 0;
		while ((mag >> size) != 0)
			size++;
		bits = (v < 0) ? (~mag & ((1 << size) - 1)) : mag;
	endfunction

	function automatic void dc_code_of(input int size, output int code, output int len);
		case (size)
			0:       begin code = 'h000; len = 2; end
			1:       begin code = 'h002; len = 3; end
			2:       begin code = 'h003; len = 3; end
			3:       begin code = 'h004; len = 3; end
			4:       begin code = 'h005; len = 3; end
			5:       begin code = 'h006; len = 3; end
			6:       begin code = 'h00E; len = 4; end
			7:       begin code = 'h01E; len = 5; end
			8:       begin code = 'h03E; len = 6; end
			9:       begin code = 'h07E; len = 7; end
			10:      begin code = 'h0FE; len = 8; end
			default: begin code = 'h1FE; len = 9; end
		endcase
	endfunction

	// Returns 0 when the run/size pair has no code.
	function automatic bit ac_code_of(input int run, input int size, output int code,
			output int len);
		bit hit;
		hit  = 1'b1;
		code = 0;
		len  = 0;
		case (run * 16 + size)
			'h01:    begin code = 'h0000; len = 2;  end
			'h02:    begin code = 'h0001; len = 2;  end
			'h03:    begin code = 'h0004; len = 3;  end
			'h04:    begin code = 'h000B; len = 4;  end
			'h05:    begin code = 'h001A; len = 5;  end
			'h06:    begin code = 'h0078; len = 7;  end
			'h11:    begin code = 'h000C; len = 4;  end
			'h12:    begin code = 'h001B; len = 5;  end
			'h13:    begin code = 'h0079; len = 7;  end
			'h14:    begin code = 'h01F6; len = 9;  end
			'h15:    begin code = 'h07F6; len = 11; end
			'h16:    begin code = 'hFF84; len = 16; end
			'h51:    begin code = 'h007A; len = 7;  end
			'h62:    begin code = 'h0FF6; len = 12; end
			'hA1:    begin code = 'h01FA; len = 9;  end
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

	task automatic predict_codeword(input logic [1:0] f,
			input logic signed [COEFF_BITS-1:0] c, input logic signed [COEFF_BITS-1:0] p);
		res_t word;
		int   size;
		int   bits;
		int   code;
		int   len;
		word = '0;
		case (f)
			FUNC_DC: begin
				zero_count = '0;
				amplitude_of(int'(c) - int'(p), size, bits);
				if (size > DC_TOP_SIZE) begin
					word.status = 1'b1;
				end else begin
					dc_code_of(size, code, len);
					word.bits = CODE_W'((code << size) | bits);
					word.len  = LEN_W'(len + size);
				end
				expected_codes = {expected_codes, word};
			end
			FUNC_EOB: begin
				zero_count = '0;
				word.bits  = EOB_CODE;
				word.len   = EOB_LEN;
				expected_codes = {expected_codes, word};
			end
			FUNC_AC: begin
				if (c == 0) begin
					if (zero_count < RUN_LIMIT)
						zero_count++;
				end else begin
					amplitude_of(int'(c), size, bits);
					if (ac_code_of(int'(zero_count), size, code, len)) begin
						word.bits = CODE_W'((code << size) | bits);
						word.len  = LEN_W'(len + size);
					end else begin
						word.status = 1'b1;
					end
					zero_count = '0;
					expected_codes = {expected_codes, word};
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			zero_count = '0;
			expected_codes.delete();
			waiting = 0;
		end else begin
			if (item_valid && !item_stall)
				predict_codeword(func, coefficient, prev_dc);
			if (result_valid && !result_stall) begin
				if (expected_codes.size() == 0) begin
					fails++;
					$display("%0t: unexpected result, expected none, actual %h/%0d/%0d",
						$time, code_bits, code_length, status);
				end else begin
					want = expected_codes.pop_front();
					if (code_bits !== want.bits) begin
						fails++;
						$display("%0t: code_bits expected %h, actual %h", $time,
							want.bits, code_bits);
					end
					if (code_length !== want.len) begin
						fails++;
						$display("%0t: code_length expected %0d, actual %0d", $time, want.len,
							code_length);
					end
					if (status !== want.status) begin
						fails++;
						$display("%0t: status expected %0d, actual %0d", $time,
							want.status, status);
					end
				end
			end
			waiting = expected_codes.size();
		end
	end

endmodule

>>> tb/jpeg_block_huffman_encoder_core_test.sv
// Top of the JPEG block Huffman encoder testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module jpeg_block_huffman_encoder_core_test;
	import jbhe_pkg::*;

	// Run shape. Every accepted item transaction is counted, with or without a result.
	localparam int RESET_CYCLES  = 5;
	localparam int TARGET_ITEMS  = 1600;
	localparam int CALM_AFTER    = 1400;
	localparam int HOLD_CYCLES   = 200;
	localparam int SETTLE_CYCLES = 4;
	localparam int CYCLE_LIMIT   = 500000;

	logic                         clk          = 1'b0;
	logic                         arst_n       = 1'b0;
	logic                         item_valid   = 1'b0;
	logic                         item_stall;
	logic [1:0]                   func         = FUNC_DC;
	logic signed [COEFF_BITS-1:0] coefficient  = '0;
	logic signed [COEFF_BITS-1:0] prev_dc      = '0;
	logic                         result_valid;
	logic                         result_stall = 1'b0;
	logic [CODE_W-1:0]            code_bits;
	logic [LEN_W-1:0]             code_length;
	logic                         status;

	int fail_count;
	int pending;
	int sent_items  = 0;
	int cycle_count = 0;
	bit calm        = 1'b0;   // no idling on either side in the last part of the run
	bit gaps_on     = 1'b1;   // sender may idle between transactions
	bit hold_req    = 1'b0;   // asks the receiver for one long hold-off

	always #4 clk = ~clk;

	jpeg_block_huffman_encoder_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.func         (func),
		.coefficient  (coefficient),
		.prev_dc      (prev_dc),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.code_bits    (code_bits),
		.code_length  (code_length),
		.status       (status)
	);

	jpeg_block_huffman_encoder_core_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.func         (func),
		.coefficient  (coefficient),
		.prev_dc      (prev_dc),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.code_bits    (code_bits),
		.code_length  (code_length),
		.status       (status),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Sender idles with valid low. The payload wanders while valid is low, so a block
	// that wrongly takes an invalid transaction shows up as an unexpected result.
	task automatic pause_sender(input int n);
		repeat (n) begin
			@(negedge clk);
			item_valid  <= 1'b0;
			func        <= 2'($urandom);
			coefficient <= COEFF_BITS'($urandom);
			prev_dc     <= COEFF_BITS'($urandom);
		end
	endtask

	// Presents one item at a falling edge and holds it until a rising edge takes it.
	// Valid stays high when the next item follows directly, so it is never dropped
	// and raised again within one time step.
	task automatic offer(input logic [1:0] f, input int c, input int p);
		if (gaps_on && !calm && $urandom_range(0, 5) == 0)
			pause_sender($urandom_range(1, 16));
		@(negedge clk);
		item_valid  <= 1'b1;
		func        <= f;
		coefficient <= COEFF_BITS'(c);
		prev_dc     <= COEFF_BITS'(p);
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		sent_items++;
	endtask

	// Lets the encoder run dry: every predicted codeword has arrived and the
	// pipeline has had time to show anything extra.
	task automatic drain();
		@(negedge clk);
		item_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	function automatic int any_value();
		return $urandom_range(0, 4095) - 2048;
	endfunction

	// A value whose magnitude has exactly the given bit length; zero for size zero.
	function automatic int value_of_size(input int size);
		int mag;
		if (size == 0)
			return 0;
		if (size >= 12)
			return -2048;
		mag = $urandom_range((1 << size) - 1, 1 << (size - 1));
		return ($urandom_range(0, 1) != 0) ? -mag : mag;
	endfunction

	// One block as a zig-zag scanner would deliver it: a DC item, a few run/size
	// pairs that mostly hit the AC table, then end-of-block. Now and then the block
	// is broken: an odd size, a run past saturation, a missing end or a stray item.
	task automatic send_block();
		int pairs;
		int run;
		int size;
		int p;
		if ($urandom_range(0, 2) == 0) begin
			offer(FUNC_DC, any_value(), any_value());
		end else begin
			p = $urandom_range(0, 1023) - 512;
			offer(FUNC_DC, p + value_of_size($urandom_range(0, 10)), p);
		end
		pairs = $urandom_range(0, 8);
		repeat (pairs) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: run = 0;
				4, 5:       run = 1;
				6:          run = 5;
				7:          run = 6;
				8:          run = 10;
				default:    run = $urandom_range(0, 70);
			endcase
			case (run)
				0, 1:    size = $urandom_range(1, 6);
				5, 10:   size = 1;
				6:       size = 2;
				default: size = $urandom_range(1, 12);
			endcase
			if ($urandom_range(0, 7) == 0)
				size = $urandom_range(1, 12);
			repeat (run)
				offer(FUNC_AC, 0, any_value());
			offer(FUNC_AC, value_of_size(size), any_value());
		end
		if ($urandom_range(0, 5) == 0)
			offer(2'($urandom_range(0, 3)), any_value(), any_value());
		if ($urandom_range(0, 7) != 0)
			offer(FUNC_EOB, any_value(), any_value());
	endtask

	// Receiver: random stall bursts, plus one long hold-off on request so that the
	// encoder fills up and has to stall its input.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES)
					@(negedge clk);
				result_stall <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 16))
					@(negedge clk);
				result_stall <= 1'b0;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	initial begin
		repeat (RESET_CYCLES)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part. DC differences at both ends of the table and past it.
		offer(FUNC_DC, 0, 0);
		offer(FUNC_DC, 2047, 0);
		offer(FUNC_DC, -1024, 0);
		offer(FUNC_DC, 2047, -2048);
		offer(FUNC_DC, -2048, 2047);
		// AC values around the run-zero entries, including one too wide for the table.
		offer(FUNC_AC, 1, -2048);
		offer(FUNC_AC, -1, 2047);
		offer(FUNC_AC, 63, 0);
		offer(FUNC_AC, -64, 0);
		offer(FUNC_AC, 0, 0);
		offer(FUNC_AC, -2, 0);
		// A DC item clears the run, and a zero DC difference adds nothing to it.
		offer(FUNC_AC, 0, 0);
		offer(FUNC_AC, 0, 0);
		offer(FUNC_DC, 3, 5);
		offer(FUNC_AC, 0, 0);
		offer(FUNC_DC, 7, 7);
		offer(FUNC_AC, 1, 0);
		offer(FUNC_AC, 2047, 0);
		offer(FUNC_AC, -2048, 0);
		offer(FUNC_EOB, 2047, -2048);
		offer(FUNC_RSV, -1, -1);
		// The sparse entries for longer runs.
		repeat (5)
			offer(FUNC_AC, 0, 0);
		offer(FUNC_AC, 1, 0);
		repeat (6)
			offer(FUNC_AC, 0, 0);
		offer(FUNC_AC, 3, 0);
		repeat (10)
			offer(FUNC_AC, 0, 0);
		offer(FUNC_AC, -1, 0);
		// End-of-block clears a pending run.
		offer(FUNC_AC, 0, 0);
		offer(FUNC_EOB, 0, 0);
		offer(FUNC_AC, 1, 0);
		drain();

		// Back-to-back blocks against a long receiver hold-off.
		gaps_on  = 1'b0;
		hold_req = 1'b1;
		repeat (12)
			send_block();
		gaps_on = 1'b1;

		// Random blocks, some with sender idling and some without, with an
		// occasional full drain in between.
		while (sent_items < CALM_AFTER) begin
			gaps_on = ($urandom_range(0, 3) != 0);
			send_block();
			if ($urandom_range(0, 40) == 0)
				drain();
		end

		// Last part at full rate on both sides.
		calm = 1'b1;
		while (sent_items < TARGET_ITEMS)
			send_block();
		drain();

		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> jpeg_block_huffman_encoder_core.f
sv/jbhe_pkg.sv
sv/jbhe_amp.sv
sv/jbhe_code.sv
sv/jpeg_block_huffman_encoder_core.sv
tb/jpeg_block_huffman_encoder_core_checker.sv
tb/jpeg_block_huffman_encoder_core_test.sv
